// ----- rtl/angle_unwrap_velocity_tracker_defines.svh -----
// ----------------------------------------------------------------------------
// angle unwrap velocity tracker: assertion macros
// shared property forms for the checker, same-cycle and next-cycle implication
// ----------------------------------------------------------------------------
`ifndef ANGLE_UNWRAP_VELOCITY_TRACKER_DEFINES_SVH
`define ANGLE_UNWRAP_VELOCITY_TRACKER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define AUVT_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("auvt same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define AUVT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("auvt next-cycle check failed");

`endif

// ----- rtl/auvt_pkg.sv -----
// ----------------------------------------------------------------------------
// auvt_pkg
// widths, codes and state encoding shared by the angle unwrap tracker
// ----------------------------------------------------------------------------
package auvt_pkg;

  localparam int ANGLE_BITS    = 12;
  localparam int VEL_FRAC_BITS = 8;
  localparam int DELTA_W       = ANGLE_BITS + 1;
  localparam int UNWRAP_W      = 32;
  localparam int VEL_W         = 40;
  localparam int DT_W          = 16;
  localparam int TAU_W         = 24;
  localparam int FAIL_W        = 8;
  localparam int MASK_W        = 8;
  localparam int PERIOD_W      = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 24;

  // filter numerator and divisor
  localparam int NUM_W         = VEL_W + DT_W + 2;
  localparam int DEN_W         = TAU_W + 1;
  localparam int DIV_STEPS     = 2;
  localparam int Q_DIGITS      = NUM_W / DIV_STEPS;
  localparam int DIV_CNT_W     = $clog2(Q_DIGITS);

  // shared multiplier, velocity split into a low and a high half
  localparam int VEL_SPLIT     = 20;
  localparam int MUL_W         = VEL_SPLIT + 1;
  localparam int PROD_W        = 2 * MUL_W;
  localparam logic signed [MUL_W-1:0] US_PER_S = MUL_W'(1000000);

  localparam logic [FAIL_W-1:0] FAIL_SAT = {FAIL_W{1'b1}};

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_FAIL   = 2'd1,
    OP_STATUS = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAU           = 2'd0,
    CFG_MAX_FAILURES  = 2'd1,
    CFG_MAGNET_MASK   = 2'd2,
    CFG_STATUS_PERIOD = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MUL_DELTA,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/angle_unwrap_velocity_tracker.sv -----
// ----------------------------------------------------------------------------
// angle_unwrap_velocity_tracker
// flow: a good angle sample goes through the delta, multiply, accumulate,
//   divide, sign and finish states; failure, status and ignored beats go
//   straight to finish; the block takes no beat while an item is in work,
//   and a sample stays in work through the 29 passes of the radix-4 divider
// reset: synchronous rst restores register defaults and clears the tracker state
// ----------------------------------------------------------------------------
module angle_unwrap_velocity_tracker (
  input  logic                                     clk,
  input  logic                                     rst,

  // configuration write channel
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [auvt_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [auvt_pkg::CFG_DATA_W-1:0]          cfg_data,

  // input items
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [1:0]                               operation,
  input  logic [auvt_pkg::ANGLE_BITS-1:0]          raw_angle,
  input  logic [auvt_pkg::DT_W-1:0]                dt_us,
  input  logic [auvt_pkg::MASK_W-1:0]              status_byte,

  // result items
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     ok,
  output logic [auvt_pkg::ANGLE_BITS-1:0]          angle_counts,
  output logic signed [auvt_pkg::UNWRAP_W-1:0]     unwrapped_counts,
  output logic signed [auvt_pkg::VEL_W-1:0]        velocity,
  output logic [auvt_pkg::FAIL_W-1:0]              failure_count,
  output logic                                     healthy,
  output logic                                     magnet_ok,
  output logic                                     status_due
);

  localparam int SUM_W = auvt_pkg::NUM_W + 2;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [auvt_pkg::TAU_W-1:0]    velocity_tau_us;
  logic [auvt_pkg::FAIL_W-1:0]   max_failures;
  logic [auvt_pkg::MASK_W-1:0]   magnet_mask;
  logic [auvt_pkg::PERIOD_W-1:0] status_period;

  // writes are to be made only while idle; the block does not enforce it, and the port is always open
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_tau_us <= auvt_pkg::TAU_W'(20000);
      max_failures    <= auvt_pkg::FAIL_W'(5);
      magnet_mask     <= auvt_pkg::MASK_W'(32);
      status_period   <= auvt_pkg::PERIOD_W'(100);
    end else if (cfg_valid) begin
      unique case (auvt_pkg::cfg_idx_t'(cfg_index))
        auvt_pkg::CFG_TAU: begin
          velocity_tau_us <= cfg_data[auvt_pkg::TAU_W-1:0];
        end
        auvt_pkg::CFG_MAX_FAILURES: begin
          max_failures <= cfg_data[auvt_pkg::FAIL_W-1:0];
        end
        auvt_pkg::CFG_MAGNET_MASK: begin
          magnet_mask <= cfg_data[auvt_pkg::MASK_W-1:0];
        end
        auvt_pkg::CFG_STATUS_PERIOD: begin
          status_period <= cfg_data[auvt_pkg::PERIOD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // tracker state
  // --------------------------------------------------------------------------
  logic [auvt_pkg::ANGLE_BITS-1:0]      last_angle;
  logic                                 seen_sample;
  logic [auvt_pkg::UNWRAP_W-1:0]        unwrapped_total;
  logic signed [auvt_pkg::VEL_W-1:0]    velocity_estimate;
  logic [auvt_pkg::FAIL_W-1:0]          fail_count;
  logic [auvt_pkg::PERIOD_W-1:0]        sample_divider;
  logic [auvt_pkg::MASK_W-1:0]          status_copy;
  logic                                 health_flag;

  logic [auvt_pkg::ANGLE_BITS-1:0]      last_angle_next;
  logic                                 seen_sample_next;
  logic [auvt_pkg::UNWRAP_W-1:0]        unwrapped_total_next;
  logic signed [auvt_pkg::VEL_W-1:0]    velocity_estimate_next;
  logic [auvt_pkg::FAIL_W-1:0]          fail_count_next;
  logic [auvt_pkg::PERIOD_W-1:0]        sample_divider_next;
  logic [auvt_pkg::MASK_W-1:0]          status_copy_next;
  logic                                 health_flag_next;
  logic                                 ok_next;
  logic                                 due_next;

  // --------------------------------------------------------------------------
  // captured item and datapath registers
  // --------------------------------------------------------------------------
  auvt_pkg::op_t                        op_q;
  logic [auvt_pkg::ANGLE_BITS-1:0]      raw_q;
  logic [auvt_pkg::DT_W-1:0]            dt_q;
  logic [auvt_pkg::MASK_W-1:0]          sbyte_q;
  logic signed [auvt_pkg::DELTA_W-1:0]  delta_q;
  logic signed [auvt_pkg::PROD_W-1:0]   prod;
  logic signed [auvt_pkg::NUM_W-1:0]    acc;
  logic                                 num_neg;
  logic signed [auvt_pkg::NUM_W:0]      q_signed;
  logic                                 ok_q;
  logic                                 due_q;

  auvt_pkg::state_t                     state;
  auvt_pkg::state_t                     state_next;

  logic                                 in_beat;
  logic                                 finish_fire;
  logic                                 div_start;
  logic                                 div_done;
  logic [auvt_pkg::NUM_W-1:0]           div_quotient;
  logic [auvt_pkg::NUM_W-1:0]           div_dividend;
  logic [auvt_pkg::DEN_W-1:0]           div_divisor;

  assign in_ready    = (state == auvt_pkg::ST_IDLE);
  assign in_beat     = in_valid && in_ready;
  // results land in the output slot only once the previous beat has gone
  assign finish_fire = (state == auvt_pkg::ST_FINISH) && (!out_valid || out_ready);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= auvt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      auvt_pkg::ST_IDLE: begin
        if (in_valid) begin
          // only a good sample needs the filter; the rest go straight to update
          if (operation == auvt_pkg::OP_SAMPLE && dt_us != '0) begin
            state_next = auvt_pkg::ST_DELTA;
          end else begin
            state_next = auvt_pkg::ST_FINISH;
          end
        end
      end
      auvt_pkg::ST_DELTA:     state_next = auvt_pkg::ST_MUL_DELTA;
      auvt_pkg::ST_MUL_DELTA: state_next = auvt_pkg::ST_MUL_LO;
      auvt_pkg::ST_MUL_LO:    state_next = auvt_pkg::ST_MUL_HI;
      auvt_pkg::ST_MUL_HI:    state_next = auvt_pkg::ST_ACC;
      auvt_pkg::ST_ACC:       state_next = auvt_pkg::ST_DIV_LOAD;
      auvt_pkg::ST_DIV_LOAD: begin
        div_start  = 1'b1;
        state_next = auvt_pkg::ST_DIV_WAIT;
      end
      auvt_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = auvt_pkg::ST_SIGN;
        end
      end
      auvt_pkg::ST_SIGN:      state_next = auvt_pkg::ST_FINISH;
      auvt_pkg::ST_FINISH: begin
        if (finish_fire) begin
          state_next = auvt_pkg::ST_IDLE;
        end
      end
      default:                state_next = auvt_pkg::ST_IDLE;
    endcase
  end

  // capture the item on its beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_q    <= auvt_pkg::op_t'(operation);
      raw_q   <= raw_angle;
      dt_q    <= dt_us;
      sbyte_q <= status_byte;
    end
  end

  // --------------------------------------------------------------------------
  // angle difference, wrapped into half a turn either way; exactly half a
  // turn is kept as it is; on the first sample the base is the sample itself
  // --------------------------------------------------------------------------
  localparam logic signed [auvt_pkg::DELTA_W:0] ANGLE_HALF =
    (auvt_pkg::DELTA_W + 1)'(2 ** (auvt_pkg::ANGLE_BITS - 1));
  localparam logic signed [auvt_pkg::DELTA_W:0] ANGLE_FULL =
    (auvt_pkg::DELTA_W + 1)'(2 ** auvt_pkg::ANGLE_BITS);

  logic [auvt_pkg::ANGLE_BITS-1:0]      angle_base;
  logic signed [auvt_pkg::DELTA_W:0]    diff_raw;
  logic signed [auvt_pkg::DELTA_W:0]    diff_wrap;

  always_comb begin
    angle_base = seen_sample ? last_angle : raw_q;
    diff_raw   = $signed({2'b00, raw_q}) - $signed({2'b00, angle_base});
    if (diff_raw > ANGLE_HALF) begin
      diff_wrap = diff_raw - ANGLE_FULL;
    end else if (diff_raw < -ANGLE_HALF) begin
      diff_wrap = diff_raw + ANGLE_FULL;
    end else begin
      diff_wrap = diff_raw;
    end
  end

  // --------------------------------------------------------------------------
  // shared multiplier: delta * 1e6, then the two halves of vel * dt
  // --------------------------------------------------------------------------
  logic signed [auvt_pkg::MUL_W-1:0]    mul_a;
  logic signed [auvt_pkg::MUL_W-1:0]    mul_b;
  logic signed [auvt_pkg::PROD_W-1:0]   prod_c;
  logic signed [auvt_pkg::NUM_W-1:0]    prod_ext;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      auvt_pkg::ST_MUL_DELTA: begin
        mul_a = {{(auvt_pkg::MUL_W - auvt_pkg::DELTA_W){delta_q[auvt_pkg::DELTA_W-1]}},
                 delta_q};
        mul_b = auvt_pkg::US_PER_S;
      end
      auvt_pkg::ST_MUL_LO: begin
        mul_a = {1'b0, velocity_estimate[auvt_pkg::VEL_SPLIT-1:0]};
        mul_b = {{(auvt_pkg::MUL_W - auvt_pkg::DT_W){1'b0}}, dt_q};
      end
      auvt_pkg::ST_MUL_HI: begin
        mul_a = {{(auvt_pkg::MUL_W - auvt_pkg::VEL_W + auvt_pkg::VEL_SPLIT)
                  {velocity_estimate[auvt_pkg::VEL_W-1]}},
                 velocity_estimate[auvt_pkg::VEL_W-1:auvt_pkg::VEL_SPLIT]};
        mul_b = {{(auvt_pkg::MUL_W - auvt_pkg::DT_W){1'b0}}, dt_q};
      end
      default: begin
      end
    endcase
  end

  assign prod_c   = mul_a * mul_b;
  assign prod_ext = {{(auvt_pkg::NUM_W - auvt_pkg::PROD_W){prod[auvt_pkg::PROD_W-1]}}, prod};

  // numerator built one partial product per cycle:
  // num = delta * 1e6 * 2^frac - vel_lo * dt - vel_hi * dt * 2^split
  always_ff @(posedge clk) begin
    prod <= prod_c;
    unique case (state)
      auvt_pkg::ST_DELTA:  delta_q <= auvt_pkg::DELTA_W'(diff_wrap);
      auvt_pkg::ST_MUL_LO: acc     <= prod_ext <<< auvt_pkg::VEL_FRAC_BITS;
      auvt_pkg::ST_MUL_HI: acc     <= acc - prod_ext;
      auvt_pkg::ST_ACC:    acc     <= acc - (prod_ext <<< auvt_pkg::VEL_SPLIT);
      auvt_pkg::ST_DIV_LOAD: begin
        num_neg <= acc[auvt_pkg::NUM_W-1];
      end
      auvt_pkg::ST_SIGN: begin
        // divisor is positive, so the quotient takes the numerator's sign
        q_signed <= num_neg ? -$signed({1'b0, div_quotient})
                            :  $signed({1'b0, div_quotient});
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // divide the magnitude by tau + dt
  // --------------------------------------------------------------------------
  assign div_dividend = acc[auvt_pkg::NUM_W-1] ? auvt_pkg::NUM_W'(-acc)
                                               : auvt_pkg::NUM_W'(acc);
  assign div_divisor  = {1'b0, velocity_tau_us}
                      + {{(auvt_pkg::DEN_W - auvt_pkg::DT_W){1'b0}}, dt_q};

  auvt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // --------------------------------------------------------------------------
  // state update for the item in hand
  // --------------------------------------------------------------------------
  localparam int VELW_TOP = auvt_pkg::VEL_W - 1;

  logic signed [SUM_W-1:0]              vel_sum;
  logic [SUM_W-VELW_TOP-1:0]            vel_top;
  logic signed [auvt_pkg::VEL_W-1:0]    vel_sat;
  logic [auvt_pkg::FAIL_W-1:0]          fail_inc;
  logic [auvt_pkg::PERIOD_W-1:0]        divider_inc;
  logic                                 magnet_now;
  logic                                 magnet_byte;

  always_comb begin
    vel_sum = {{(SUM_W - auvt_pkg::VEL_W){velocity_estimate[auvt_pkg::VEL_W-1]}},
               velocity_estimate}
            + {{(SUM_W - auvt_pkg::NUM_W - 1){q_signed[auvt_pkg::NUM_W]}}, q_signed};
    vel_top = vel_sum[SUM_W-1:VELW_TOP];
    // in range only when every bit above the 40-bit sign agrees with it
    if ((&vel_top) || !(|vel_top)) begin
      vel_sat = vel_sum[auvt_pkg::VEL_W-1:0];
    end else if (vel_sum[SUM_W-1]) begin
      vel_sat = {1'b1, {(auvt_pkg::VEL_W - 1){1'b0}}};
    end else begin
      vel_sat = {1'b0, {(auvt_pkg::VEL_W - 1){1'b1}}};
    end
  end

  assign fail_inc    = (fail_count == auvt_pkg::FAIL_SAT) ? fail_count
                                                          : fail_count + auvt_pkg::FAIL_W'(1);
  assign divider_inc = sample_divider + auvt_pkg::PERIOD_W'(1);
  assign magnet_now  = |(status_copy & magnet_mask);
  assign magnet_byte = |(sbyte_q & magnet_mask);

  always_comb begin
    last_angle_next        = last_angle;
    seen_sample_next       = seen_sample;
    unwrapped_total_next   = unwrapped_total;
    velocity_estimate_next = velocity_estimate;
    fail_count_next        = fail_count;
    sample_divider_next    = sample_divider;
    status_copy_next       = status_copy;
    health_flag_next       = health_flag;
    ok_next                = 1'b0;
    due_next               = 1'b0;
    case (op_q)
      auvt_pkg::OP_SAMPLE: begin
        if (dt_q != '0) begin
          last_angle_next        = raw_q;
          seen_sample_next       = 1'b1;
          // first sample loads the count with the angle itself
          unwrapped_total_next   = (seen_sample ? unwrapped_total
                                    : {{(auvt_pkg::UNWRAP_W - auvt_pkg::ANGLE_BITS){1'b0}},
                                       raw_q})
                                 + {{(auvt_pkg::UNWRAP_W - auvt_pkg::DELTA_W)
                                     {delta_q[auvt_pkg::DELTA_W-1]}}, delta_q};
          velocity_estimate_next = vel_sat;
          fail_count_next        = '0;
          if (divider_inc >= status_period) begin
            sample_divider_next = '0;
            due_next            = 1'b1;
          end else begin
            sample_divider_next = divider_inc;
          end
          health_flag_next = magnet_now;
          ok_next          = magnet_now && (max_failures != '0);
        end else begin
          // a zero interval counts as a read failure
          fail_count_next = fail_inc;
          if (fail_inc >= max_failures) begin
            health_flag_next = 1'b0;
          end
        end
      end
      auvt_pkg::OP_FAIL: begin
        fail_count_next = fail_inc;
        if (fail_inc >= max_failures) begin
          health_flag_next = 1'b0;
        end
      end
      auvt_pkg::OP_STATUS: begin
        status_copy_next = sbyte_q;
        health_flag_next = magnet_byte;
        ok_next          = seen_sample && magnet_byte && (fail_count < max_failures);
      end
      default: begin
        // unknown operation leaves everything alone
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle        <= '0;
      seen_sample       <= 1'b0;
      unwrapped_total   <= '0;
      velocity_estimate <= '0;
      fail_count        <= '0;
      sample_divider    <= '0;
      status_copy       <= '0;
      health_flag       <= 1'b0;
      out_valid         <= 1'b0;
      ok_q              <= 1'b0;
      due_q             <= 1'b0;
    end else begin
      if (finish_fire) begin
        last_angle        <= last_angle_next;
        seen_sample       <= seen_sample_next;
        unwrapped_total   <= unwrapped_total_next;
        velocity_estimate <= velocity_estimate_next;
        fail_count        <= fail_count_next;
        sample_divider    <= sample_divider_next;
        status_copy       <= status_copy_next;
        health_flag       <= health_flag_next;
        ok_q              <= ok_next;
        due_q             <= due_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result beat: state only moves on a finish, which waits for the slot to
  // empty, so the fields hold while a result is stalled, as long as no
  // register is written
  assign ok               = ok_q;
  assign status_due       = due_q;
  assign angle_counts     = last_angle;
  assign unwrapped_counts = unwrapped_total;
  assign velocity         = velocity_estimate;
  assign failure_count    = fail_count;
  assign healthy          = seen_sample && health_flag && (fail_count < max_failures);
  assign magnet_ok        = magnet_now;

endmodule

// ----- rtl/auvt_div.sv -----
// ----------------------------------------------------------------------------
// auvt_div
// unsigned restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module auvt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [auvt_pkg::NUM_W-1:0]    dividend,
  input  logic [auvt_pkg::DEN_W-1:0]    divisor,
  output logic                          done,
  output logic [auvt_pkg::NUM_W-1:0]    quotient
);

  logic                              busy;
  logic [auvt_pkg::DIV_CNT_W-1:0]    cnt;
  logic [auvt_pkg::NUM_W-1:0]        work;
  logic [auvt_pkg::NUM_W-1:0]        work_next;
  logic [auvt_pkg::DEN_W-1:0]        rem;
  logic [auvt_pkg::DEN_W-1:0]        rem_next;
  logic [auvt_pkg::DEN_W-1:0]        dsr;
  logic [auvt_pkg::DEN_W:0]          trial;

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_comb begin
    work_next = work;
    rem_next  = rem;
    trial     = '0;
    for (int i = 0; i < auvt_pkg::DIV_STEPS; i++) begin
      trial     = {rem_next, work_next[auvt_pkg::NUM_W-1]};
      work_next = {work_next[auvt_pkg::NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial        = trial - {1'b0, dsr};
        work_next[0] = 1'b1;
      end
      rem_next = trial[auvt_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        work <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= auvt_pkg::DIV_CNT_W'(auvt_pkg::Q_DIGITS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        work <= work_next;
        rem  <= rem_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - auvt_pkg::DIV_CNT_W'(1);
        end
      end
    end
  end

  assign quotient = work;

endmodule

// ----- rtl/auvt_checker.sv -----
// ----------------------------------------------------------------------------
// auvt_checker
// port-level checks on the angle unwrap tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "angle_unwrap_velocity_tracker_defines.svh"

module auvt_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  ok,
  input logic signed [auvt_pkg::UNWRAP_W-1:0]  unwrapped_counts,
  input logic signed [auvt_pkg::VEL_W-1:0]     velocity,
  input logic [auvt_pkg::FAIL_W-1:0]           failure_count,
  input logic                                  healthy,
  input logic                                  status_due
);

  // one item in work at a time
  `AUVT_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready)

  // a stalled result holds its value
  `AUVT_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(velocity) && $stable(unwrapped_counts))

  // success implies health
  `AUVT_ASSERT_NOW(a_ok_implies_healthy, clk, rst, out_valid && ok, healthy)

  // status requests only come from good samples
  `AUVT_ASSERT_NOW(a_due_on_good_sample, clk, rst, out_valid && status_due, failure_count == '0 && ok == healthy)

endmodule

bind angle_unwrap_velocity_tracker auvt_checker u_auvt_checker (.*);

// ----- bench/auvt_tracker_checker.sv -----
// ----------------------------------------------------------------------------
// auvt_tracker_checker
// watches the config, item and result channels of the angle unwrap tracker,
// keeps its own copy of the unwrap, filter and health state, and compares
// every result beat field by field with the oldest predicted report
// ----------------------------------------------------------------------------
module auvt_tracker_checker
  import auvt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 operation,
  input  logic [ANGLE_BITS-1:0]      raw_angle,
  input  logic [DT_W-1:0]            dt_us,
  input  logic [MASK_W-1:0]          status_byte,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       ok,
  input  logic [ANGLE_BITS-1:0]      angle_counts,
  input  logic signed [UNWRAP_W-1:0] unwrapped_counts,
  input  logic signed [VEL_W-1:0]    velocity,
  input  logic [FAIL_W-1:0]          failure_count,
  input  logic                       healthy,
  input  logic                       magnet_ok,
  input  logic                       status_due,
  output int                         mismatch_count,
  output int                         pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HALF_TURN = longint'(1) << (ANGLE_BITS - 1);
  localparam longint FULL_TURN = longint'(1) << ANGLE_BITS;
  localparam longint VEL_TOP   = 64'sd549755813887;
  localparam longint VEL_FLOOR = -64'sd549755813888;

  typedef struct packed {
    logic                  ok;
    logic [ANGLE_BITS-1:0] angle;
    logic [UNWRAP_W-1:0]   turns;
    logic [VEL_W-1:0]      vel;
    logic [FAIL_W-1:0]     fails;
    logic                  healthy;
    logic                  magnet;
    logic                  due;
  } tracker_report_t;

  tracker_report_t report_queue[$];
  int              error_tally;

  // register copies
  logic [TAU_W-1:0]    tau_cfg;
  logic [FAIL_W-1:0]   fail_limit;
  logic [MASK_W-1:0]   mask_cfg;
  logic [PERIOD_W-1:0] period_cfg;

  // tracker state
  logic [ANGLE_BITS-1:0] prev_angle;
  logic                  have_angle;
  logic [UNWRAP_W-1:0]   turn_total;
  longint                vel_est;
  logic [FAIL_W-1:0]     fail_run;
  logic [PERIOD_W-1:0]   sample_ctr;
  logic [MASK_W-1:0]     status_reg;
  logic                  health_latch;

  assign mismatch_count = error_tally;

  function automatic logic magnet_seen();
    return (status_reg & mask_cfg) != '0;
  endfunction

  function automatic logic healthy_now();
    return have_angle && health_latch && (fail_run < fail_limit);
  endfunction

  function automatic tracker_report_t track_item(logic [1:0] op,
                                                 logic [ANGLE_BITS-1:0] ang,
                                                 logic [DT_W-1:0] dt,
                                                 logic [MASK_W-1:0] sb);
    tracker_report_t r;
    longint step, num, den, v;
    r = '0;
    if (op == OP_SAMPLE && dt != '0) begin
      if (!have_angle) begin
        prev_angle = ang;
        turn_total = UNWRAP_W'(ang);
        have_angle = 1'b1;
      end
      step = longint'(ang) - longint'(prev_angle);
      // a difference of exactly half a turn stays as it is
      if (step > HALF_TURN) begin
        step -= FULL_TURN;
      end else if (step < -HALF_TURN) begin
        step += FULL_TURN;
      end
      num = (step <<< VEL_FRAC_BITS) * 1000000 - vel_est * longint'(dt);
      den = longint'(tau_cfg) + longint'(dt);
      v = vel_est + num / den;
      if (v > VEL_TOP) begin
        v = VEL_TOP;
      end else if (v < VEL_FLOOR) begin
        v = VEL_FLOOR;
      end
      vel_est    = v;
      turn_total = turn_total + UNWRAP_W'(step);
      prev_angle = ang;
      fail_run   = '0;
      sample_ctr = sample_ctr + 1'b1;
      if (sample_ctr >= period_cfg) begin
        sample_ctr = '0;
        r.due = 1'b1;
      end
      health_latch = magnet_seen();
      r.ok = healthy_now();
    end else if (op == OP_SAMPLE || op == OP_FAIL) begin
      if (fail_run != FAIL_SAT) begin
        fail_run = fail_run + 1'b1;
      end
      if (fail_run >= fail_limit) begin
        health_latch = 1'b0;
      end
    end else if (op == OP_STATUS) begin
      status_reg   = sb;
      health_latch = magnet_seen();
      r.ok = healthy_now();
    end
    r.angle   = prev_angle;
    r.turns   = turn_total;
    r.vel     = vel_est[VEL_W-1:0];
    r.fails   = fail_run;
    r.healthy = healthy_now();
    r.magnet  = magnet_seen();
    return r;
  endfunction

  task automatic reset_tracker();
    tau_cfg      = TAU_W'(20000);
    fail_limit   = FAIL_W'(5);
    mask_cfg     = MASK_W'(32);
    period_cfg   = PERIOD_W'(100);
    prev_angle   = '0;
    have_angle   = 1'b0;
    turn_total   = '0;
    vel_est      = 0;
    fail_run     = '0;
    sample_ctr   = '0;
    status_reg   = '0;
    health_latch = 1'b0;
  endtask

  task automatic compare_field(input string label, input logic [VEL_W-1:0] want,
                               input logic [VEL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, label, want, got);
      error_tally++;
    end
  endtask

  initial begin
    error_tally = 0;
    pending     = 0;
    reset_tracker();
  end

  always @(posedge clk) begin
    tracker_report_t want;
    if (rst) begin
      reset_tracker();
      report_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (report_queue.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          error_tally++;
        end else begin
          want = report_queue.pop_front();
          compare_field("ok", want.ok, ok);
          compare_field("angle_counts", want.angle, angle_counts);
          compare_field("unwrapped_counts", {8'h00, want.turns}, {8'h00, unwrapped_counts});
          compare_field("velocity", want.vel, velocity);
          compare_field("failure_count", want.fails, failure_count);
          compare_field("healthy", want.healthy, healthy);
          compare_field("magnet_ok", want.magnet, magnet_ok);
          compare_field("status_due", want.due, status_due);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TAU:           tau_cfg    = cfg_data[TAU_W-1:0];
          CFG_MAX_FAILURES:  fail_limit = cfg_data[FAIL_W-1:0];
          CFG_MAGNET_MASK:   mask_cfg   = cfg_data[MASK_W-1:0];
          CFG_STATUS_PERIOD: period_cfg = cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        report_queue.push_back(track_item(operation, raw_angle, dt_us, status_byte));
      end
    end
    pending <= report_queue.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives the angle unwrap tracker with directed angle, failure and status
// beats, then phases of shaped random traffic under different register
// settings and handshake idling; the checker beside the block predicts and
// compares every result, this module only makes stimulus and the verdict
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import auvt_pkg::*;

  // operation code the block must ignore
  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [1:0]                 operation;
  logic [ANGLE_BITS-1:0]      raw_angle;
  logic [DT_W-1:0]            dt_us;
  logic [MASK_W-1:0]          status_byte;
  logic                       out_valid;
  logic                       out_ready;
  logic                       ok;
  logic [ANGLE_BITS-1:0]      angle_counts;
  logic signed [UNWRAP_W-1:0] unwrapped_counts;
  logic signed [VEL_W-1:0]    velocity;
  logic [FAIL_W-1:0]          failure_count;
  logic                       healthy;
  logic                       magnet_ok;
  logic                       status_due;
  int                         mismatch_count;
  int                         pending;

  // idling odds in percent, changed per phase
  int                         send_idle_pct;
  int                         stall_pct;

  // shaping copies: last angle sent and the magnet mask in force
  logic [ANGLE_BITS-1:0]      cur_angle;
  logic [MASK_W-1:0]          cur_mask;

  angle_unwrap_velocity_tracker i_dut (.*);

  auvt_tracker_checker i_checker (.*);

  // 2 ns clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // receiver side: out_ready redrawn on every falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // one item beat: optional idle gap, then hold valid until taken;
  // returns on the falling edge after the beat without touching in_valid
  task automatic send_item(input logic [1:0] op, input logic [ANGLE_BITS-1:0] ang,
                           input logic [DT_W-1:0] dt, input logic [MASK_W-1:0] sb);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    raw_angle   <= ang;
    dt_us       <= dt;
    status_byte <= sb;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid and wait until every predicted report has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // write all four registers, only ever called with the block idle
  task automatic load_settings(input logic [TAU_W-1:0] tau, input logic [FAIL_W-1:0] maxf,
                               input logic [MASK_W-1:0] mask, input logic [PERIOD_W-1:0] per);
    cfg_idx_t                order[4];
    logic [CFG_DATA_W-1:0]   vals[4];
    order = '{CFG_TAU, CFG_MAX_FAILURES, CFG_MAGNET_MASK, CFG_STATUS_PERIOD};
    vals  = '{CFG_DATA_W'(tau), CFG_DATA_W'(maxf), CFG_DATA_W'(mask), CFG_DATA_W'(per)};
    foreach (order[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    cur_mask = mask;
  endtask

  // good sample with an explicit angle, remembered for shaping
  task automatic send_sample(input logic [ANGLE_BITS-1:0] ang, input logic [DT_W-1:0] dt);
    send_item(OP_SAMPLE, ang, dt, 8'($urandom));
    cur_angle = ang;
  endtask

  // mostly plausible motion, with failures, status beats and noise mixed in
  task automatic random_item(output bit counted);
    int                    pick;
    int                    step;
    logic [DT_W-1:0]       dt;
    logic [ANGLE_BITS-1:0] ang;
    logic [MASK_W-1:0]     sb;
    counted = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      case ($urandom_range(0, 9))
        0:       dt = DT_W'(1);
        1, 2:    dt = DT_W'($urandom_range(1, 65535));
        default: dt = DT_W'($urandom_range(50, 5000));
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: step = int'($urandom_range(0, 128)) - 64;
        12, 13, 14, 15, 16:                   step = int'($urandom_range(0, 4094)) - 2047;
        17:                                   step = 2048;
        default:                              step = int'($urandom_range(0, 4095));
      endcase
      ang = cur_angle + step[ANGLE_BITS-1:0];
      send_sample(ang, dt);
    end else if (pick < 78) begin
      send_item(OP_FAIL, 12'($urandom), 16'($urandom), 8'($urandom));
    end else if (pick < 82) begin
      // zero interval, handled as a read failure
      send_item(OP_SAMPLE, 12'($urandom), '0, 8'($urandom));
    end else if (pick < 94) begin
      sb = 8'($urandom);
      if ($urandom_range(0, 3) != 0) sb = sb | cur_mask;
      else if ($urandom_range(0, 1) != 0) sb = sb & ~cur_mask;
      send_item(OP_STATUS, 12'($urandom), 16'($urandom), sb);
    end else begin
      send_item(OP_RESERVED, 12'($urandom), 16'($urandom), 8'($urandom));
      counted = 1'b0;
    end
  endtask

  initial begin
    int done;
    bit counted;

    // every input known from time zero
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_TAU;
    cfg_data      = '0;
    in_valid      = 1'b0;
    operation     = OP_SAMPLE;
    raw_angle     = '0;
    dt_us         = '0;
    status_byte   = '0;
    out_ready     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    cur_angle     = '0;
    cur_mask      = MASK_W'(32);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part on the reset register values
    send_item(OP_RESERVED, 12'hfff, 16'hffff, 8'hff);   // ignored on an empty state
    send_item(OP_SAMPLE, 12'h123, 16'h0000, 8'h00);     // zero interval before any sample
    send_item(OP_STATUS, 12'h000, 16'h0000, 8'h20);     // magnet seen, still not healthy
    send_sample(12'hfff, 16'd1);                        // first sample loads the count
    send_sample(12'h000, 16'hffff);                     // wrap upwards by one count
    send_sample(12'd2048, 16'd1000);                    // exact half turn forwards
    send_sample(12'd0, 16'd1000);                       // exact half turn backwards
    send_sample(12'd2049, 16'd1000);                    // just past half, taken as backwards
    send_sample(12'd0, 16'd1000);
    repeat (6) send_item(OP_FAIL, 12'hfff, 16'hffff, 8'hff);  // past the failure limit
    send_sample(12'd100, 16'd500);                      // good sample clears the run
    send_item(OP_STATUS, 12'hfff, 16'hffff, 8'h00);     // magnet lost
    send_sample(12'd200, 16'd500);
    send_item(OP_STATUS, 12'h000, 16'h0000, 8'hff);
    send_sample(12'd4000, 16'd20000);
    send_item(OP_RESERVED, 12'h555, 16'haaaa, 8'h5a);   // ignored with live state
    send_item(OP_FAIL, 12'haaa, 16'h5555, 8'ha5);
    send_sample(12'hfff, 16'hffff);

    // random phases, each with its own register setting and idling mix
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: load_settings(24'd20000, 8'd5, 8'h20, 16'd100);
        1: load_settings(24'd0, 8'd1, 8'hff, 16'd1);            // no filtering
        2: load_settings(24'hffffff, 8'd255, 8'h01, 16'hffff);  // slowest filter
        3: load_settings(24'd1000, 8'd3, 8'h20, 16'd7);
        4: load_settings(24'd500, 8'd0, 8'h00, 16'd0);          // zero limit, mask, period
        5: load_settings(24'($urandom), 8'($urandom_range(1, 255)),
                         8'($urandom_range(1, 255)), 16'($urandom_range(1, 20)));
        6: load_settings(24'd300, 8'd255, 8'h80, 16'd5);
        default: load_settings(24'hffffff, 8'd1, 8'h20, 16'd2);
      endcase
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 64; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      done = 0;
      while (done < 130) begin
        // sender holds off until the block has answered everything
        if (ph == 2 && done == 80) drain();
        // long failure run to reach the saturating count
        if (ph == 6 && done == 40) begin
          repeat (260) send_item(OP_FAIL, 12'($urandom), 16'($urandom), 8'($urandom));
          done += 100;
        end
        random_item(counted);
        if (counted) done++;
      end
    end

    drain();
    repeat (48) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/auvt_pkg.sv
rtl/auvt_div.sv
rtl/angle_unwrap_velocity_tracker.sv
rtl/auvt_checker.sv
bench/auvt_tracker_checker.sv
bench/tb_top.sv
